// ===== rtl/tva_pkg.sv =====
// shared types and constants for the transformed vertex bounding box block
package tva_pkg;

  // accumulator width: three 16x32 products plus a shifted constant term
  localparam int ACC_W = 50;
  localparam int COORD_FRAC_BITS_DEF = 16;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_W = 3'd3;

  // identity matrix at reset
  localparam logic [63:0] ROW_X_RESET = 64'h0000_0000_0000_1000;
  localparam logic [63:0] ROW_Y_RESET = 64'h0000_0000_1000_0000;
  localparam logic [63:0] ROW_Z_RESET = 64'h0000_1000_0000_0000;
  localparam logic [63:0] ROW_W_RESET = 64'h1000_0000_0000_0000;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               last_vertex;
  } vertex_t;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0]        half_x;
    logic [30:0]        half_y;
    logic [30:0]        half_z;
    logic               zero_w_seen;
    logic               box_empty;
  } result_t;

  // transformed vertex handed from front to back
  typedef struct packed {
    logic signed [ACC_W-1:0] acc_x;
    logic signed [ACC_W-1:0] acc_y;
    logic signed [ACC_W-1:0] acc_z;
    logic signed [ACC_W-1:0] acc_w;
    logic                    last_vertex;
  } job_t;

endpackage

// ===== rtl/tva_fifo.sv =====
// small register queue between the transform front and the divide back
module tva_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count;
  logic do_push, do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    empty |-> (count == '0 && wptr == rptr))
    else $error("queue pointers disagree with empty count");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not follow a push");
endmodule

// ===== rtl/tva_front.sv =====
// matrix registers and the 4x4 transform, one product per cycle
module tva_front #(
  parameter int COORD_FRAC_BITS = tva_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  tva_pkg::vertex_t              vertex,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tva_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data,
  output logic                          job_push,
  output tva_pkg::job_t                 job,
  input  logic                          job_full
);
  localparam int ACC_W = tva_pkg::ACC_W;
  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_RUN  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;
  localparam logic [4:0] LAST_STEP = 5'd16;

  logic [63:0] mat [4];
  logic [1:0] state;
  logic [4:0] step;
  tva_pkg::vertex_t vtx;
  logic [1:0] row, term;
  logic signed [15:0] coef;
  logic signed [31:0] v_sel;
  logic signed [47:0] mul;
  logic signed [ACC_W-1:0] prod, prod_next;
  logic [1:0] prod_row;
  logic prod_first, prod_valid;
  logic signed [ACC_W-1:0] acc [4];

  assign cfg_ready = 1'b1;
  assign full      = (state != F_IDLE);
  assign row       = step[3:2];
  assign term      = step[1:0];
  assign coef      = mat[row][16*term +: 16];

  // operand select and product
  always_comb begin
    case (term)
      2'd0:    v_sel = vtx.pos_x;
      2'd1:    v_sel = vtx.pos_y;
      default: v_sel = vtx.pos_z;
    endcase
    mul = coef * v_sel;
    if (term == 2'd3) begin
      prod_next = ACC_W'(coef) <<< COORD_FRAC_BITS;
    end else begin
      prod_next = ACC_W'(mul);
    end
  end

  // matrix rows
  always_ff @(posedge clk) begin
    if (rst) begin
      mat[0] <= tva_pkg::ROW_X_RESET;
      mat[1] <= tva_pkg::ROW_Y_RESET;
      mat[2] <= tva_pkg::ROW_Z_RESET;
      mat[3] <= tva_pkg::ROW_W_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        tva_pkg::REG_ROW_X: mat[0] <= cfg_data;
        tva_pkg::REG_ROW_Y: mat[1] <= cfg_data;
        tva_pkg::REG_ROW_Z: mat[2] <= cfg_data;
        tva_pkg::REG_ROW_W: mat[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer over rows and terms
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_IDLE;
      step       <= '0;
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= (state == F_RUN) && (step != LAST_STEP);
      case (state)
        F_IDLE: begin
          if (push) begin
            state <= F_RUN;
            step  <= '0;
          end
        end
        F_RUN: begin
          if (step == LAST_STEP) begin
            state <= F_PUSH;
          end else begin
            step <= step + 1'b1;
          end
        end
        F_PUSH: begin
          if (!job_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  // vertex latch, product register and row accumulators
  always_ff @(posedge clk) begin
    if (state == F_IDLE && push) begin
      vtx <= vertex;
    end
    prod       <= prod_next;
    prod_row   <= row;
    prod_first <= (term == 2'd0);
    if (prod_valid) begin
      acc[prod_row] <= (prod_first ? '0 : acc[prod_row]) + prod;
    end
  end

  assign job_push        = (state == F_PUSH) && !job_full;
  assign job.acc_x       = acc[0];
  assign job.acc_y       = acc[1];
  assign job.acc_z       = acc[2];
  assign job.acc_w       = acc[3];
  assign job.last_vertex = vtx.last_vertex;
endmodule

// ===== rtl/tva_back.sv =====
// perspective divide, min and max tracking, and the result register
module tva_back #(
  parameter int COORD_FRAC_BITS = tva_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_empty,
  input  tva_pkg::job_t     job_in,
  output logic              job_pop,
  output logic              empty,
  input  logic              pop,
  output tva_pkg::result_t  result
);
  localparam int ACC_W = tva_pkg::ACC_W;
  localparam int DW = ACC_W + 32;
  localparam int INT_BITS = 32 - COORD_FRAC_BITS;
  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_SETUP = 3'd1;
  localparam logic [2:0] B_DIV   = 3'd2;
  localparam logic [2:0] B_UPD   = 3'd3;
  localparam logic [2:0] B_EMIT  = 3'd4;

  logic [2:0] state;
  tva_pkg::job_t job;
  logic [1:0] axis;
  logic [4:0] cnt;
  logic [ACC_W-1:0] rem, un, ud;
  logic [31:0] low, q;
  logic neg, ovf;
  logic signed [ACC_W-1:0] num;
  logic [DW-1:0] ud_lim;
  logic [ACC_W:0] trial;
  logic signed [31:0] quot;
  logic signed [31:0] mins [3];
  logic signed [31:0] maxs [3];
  logic have_point, zero_w_flag;
  logic out_valid;
  tva_pkg::result_t res_next;
  logic [32:0] sum [3];
  logic [32:0] diff [3];

  // divide operands
  always_comb begin
    case (axis)
      2'd0:    num = job.acc_x;
      2'd1:    num = job.acc_y;
      default: num = job.acc_z;
    endcase
    un     = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
    ud     = job.acc_w[ACC_W-1] ? ACC_W'(-job.acc_w) : ACC_W'(job.acc_w);
    ud_lim = DW'(ud) << INT_BITS;
    trial  = {rem, low[31]};
  end

  // saturated signed quotient
  always_comb begin
    if (ovf) begin
      quot = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else if (neg) begin
      quot = q[31] ? 32'sh8000_0000 : -$signed(q);
    end else begin
      quot = q[31] ? 32'sh7FFF_FFFF : $signed(q);
    end
  end

  // box center and half extents
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i]  = {mins[i][31], mins[i]} + {maxs[i][31], maxs[i]};
      diff[i] = {maxs[i][31], maxs[i]} - {mins[i][31], mins[i]};
    end
    res_next.zero_w_seen = zero_w_flag;
    res_next.box_empty   = !have_point;
    if (have_point) begin
      res_next.center_x = sum[0][32:1];
      res_next.center_y = sum[1][32:1];
      res_next.center_z = sum[2][32:1];
      res_next.half_x   = diff[0][31:1];
      res_next.half_y   = diff[1][31:1];
      res_next.half_z   = diff[2][31:1];
    end else begin
      res_next.center_x = '0;
      res_next.center_y = '0;
      res_next.center_z = '0;
      res_next.half_x   = '0;
      res_next.half_y   = '0;
      res_next.half_z   = '0;
    end
  end

  assign job_pop = (state == B_IDLE) && !job_empty;
  assign empty   = !out_valid;

  // control sequencer and run state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_IDLE;
      have_point  <= 1'b0;
      zero_w_flag <= 1'b0;
      out_valid   <= 1'b0;
      axis        <= '0;
      cnt         <= '0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (!job_empty) begin
            axis <= '0;
            if (job_in.acc_w == '0) begin
              zero_w_flag <= 1'b1;
              state       <= B_EMIT;
            end else begin
              state <= B_SETUP;
            end
          end
        end
        B_SETUP: begin
          cnt   <= '0;
          state <= (DW'(un) >= ud_lim) ? B_UPD : B_DIV;
        end
        B_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == 5'd31) begin
            state <= B_UPD;
          end
        end
        B_UPD: begin
          if (axis == 2'd2) begin
            have_point <= 1'b1;
            state      <= B_EMIT;
          end else begin
            axis  <= axis + 1'b1;
            state <= B_SETUP;
          end
        end
        B_EMIT: begin
          if (!job.last_vertex) begin
            state <= B_IDLE;
          end else if (!out_valid) begin
            out_valid   <= 1'b1;
            have_point  <= 1'b0;
            zero_w_flag <= 1'b0;
            state       <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // datapath: job latch, restoring divider, min and max, result word
  always_ff @(posedge clk) begin
    if (state == B_IDLE && !job_empty) begin
      job <= job_in;
    end
    if (state == B_SETUP) begin
      neg <= num[ACC_W-1] ^ job.acc_w[ACC_W-1];
      ovf <= (DW'(un) >= ud_lim);
      rem <= un >> INT_BITS;
      low <= 32'(DW'(un) << COORD_FRAC_BITS);
      q   <= '0;
    end
    if (state == B_DIV) begin
      low <= {low[30:0], 1'b0};
      if (trial >= {1'b0, ud}) begin
        rem <= ACC_W'(trial - {1'b0, ud});
        q   <= {q[30:0], 1'b1};
      end else begin
        rem <= trial[ACC_W-1:0];
        q   <= {q[30:0], 1'b0};
      end
    end
    if (state == B_UPD) begin
      if (!have_point || quot < mins[axis]) begin
        mins[axis] <= quot;
      end
      if (!have_point || quot > maxs[axis]) begin
        maxs[axis] <= quot;
      end
    end
    if (state == B_EMIT && job.last_vertex && !out_valid) begin
      result <= res_next;
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == B_DIV) |-> (rem < ud))
    else $error("divider remainder not below divisor");
  a_empty_box_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result.box_empty) |->
      (result.center_x == '0 && result.half_x == '0 && result.half_z == '0))
    else $error("empty box carries nonzero fields");
  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (state == B_EMIT && job.last_vertex && !out_valid) |=> out_valid)
    else $error("result word not loaded on last vertex");
endmodule

// ===== rtl/transformed_vertex_aabb.sv =====
// Bounding box of a run of vertices after a 4x4 projective transform. The
// front multiplies one coefficient per cycle (products, a flush, then a
// hand-off that waits while the queue is full) and hands the four row sums
// to a two-word queue; the back then runs one shared restoring divider, 32
// steps per axis unless the quotient saturates, while a vertex with zero w
// skips the divider. The back takes a new job from the queue only when it
// is idle again. A result word is held in an output register and the back
// keeps working while it waits to be popped, stalling only when a second
// result is ready.
module transformed_vertex_aabb #(
  parameter int COORD_FRAC_BITS = tva_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  tva_pkg::vertex_t              vertex,
  output logic                          empty,
  input  logic                          pop,
  output tva_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tva_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data
);
  logic job_push, job_full, job_pop, job_empty;
  tva_pkg::job_t job_w, job_r;

  tva_front #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .vertex(vertex),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .job_push(job_push), .job(job_w), .job_full(job_full)
  );

  tva_fifo #(.WIDTH($bits(tva_pkg::job_t)), .DEPTH(2)) u_fifo (
    .clk(clk), .rst(rst), .push(job_push), .wdata(job_w), .full(job_full),
    .pop(job_pop), .rdata(job_r), .empty(job_empty)
  );

  tva_back #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .job_empty(job_empty), .job_in(job_r),
    .job_pop(job_pop), .empty(empty), .pop(pop), .result(result)
  );
endmodule

// ===== tb/sv/tb_transformed_vertex_aabb.sv =====
// testbench for the transformed vertex bounding box block
`timescale 1ns / 1ps

module tb_transformed_vertex_aabb;

  localparam int COORD_FRAC = 16;
  localparam int SETTLE_CYCLES = 400;
  localparam longint CYCLE_LIMIT = 4000000;
  localparam logic [tva_pkg::CFG_IDX_W-1:0] REG_FIRST_UNUSED =
    tva_pkg::CFG_IDX_W'(tva_pkg::REG_ROW_W + 1);

  logic clk;
  logic rst;
  logic push;
  logic full;
  tva_pkg::vertex_t vertex;
  logic empty;
  logic pop;
  tva_pkg::result_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [tva_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [63:0] cfg_data;

  // matrix and box state mirrored from the block
  logic [63:0] mat_row [4];
  logic signed [31:0] box_lo [3];
  logic signed [31:0] box_hi [3];
  logic box_valid;
  logic saw_zero_w;

  tva_pkg::result_t box_q [$];
  int errors;
  int idle_pct;
  int stall_pct;
  int hold_left;
  longint cycle_count;

  transformed_vertex_aabb dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .vertex(vertex),
    .empty(empty), .pop(pop), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("transformed_vertex_aabb: mismatch");
      $finish;
    end
  end

  // long receiver hold-off countdown
  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // receiver with random stalls
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("error at %0t: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  // compare each popped word with the oldest expected box
  always @(posedge clk) begin
    tva_pkg::result_t want;
    if (!rst && pop && !empty) begin
      if (box_q.size() == 0) begin
        report_mismatch("unexpected result words", 1, 0);
      end else begin
        want = box_q.pop_front();
        if (result.center_x !== want.center_x)
          report_mismatch("center_x", result.center_x, want.center_x);
        if (result.center_y !== want.center_y)
          report_mismatch("center_y", result.center_y, want.center_y);
        if (result.center_z !== want.center_z)
          report_mismatch("center_z", result.center_z, want.center_z);
        if (result.half_x !== want.half_x)
          report_mismatch("half_x", result.half_x, want.half_x);
        if (result.half_y !== want.half_y)
          report_mismatch("half_y", result.half_y, want.half_y);
        if (result.half_z !== want.half_z)
          report_mismatch("half_z", result.half_z, want.half_z);
        if (result.zero_w_seen !== want.zero_w_seen)
          report_mismatch("zero_w_seen", result.zero_w_seen, want.zero_w_seen);
        if (result.box_empty !== want.box_empty)
          report_mismatch("box_empty", result.box_empty, want.box_empty);
      end
    end
  end

  // one row of the matrix times (x, y, z, 1)
  function automatic longint row_dot(logic [63:0] row, longint x, longint y, longint z);
    longint c0, c1, c2, c3;
    c0 = longint'($signed(row[15:0]));
    c1 = longint'($signed(row[31:16]));
    c2 = longint'($signed(row[47:32]));
    c3 = longint'($signed(row[63:48]));
    return c0 * x + c1 * y + c2 * z + c3 * (longint'(1) << COORD_FRAC);
  endfunction

  // trunc(n * 2^frac / d), saturated to 32 bits
  function automatic logic signed [31:0] perspective_div(longint n, longint d);
    logic neg;
    longint unsigned un, ud, q, r;
    neg = (n < 0) != (d < 0);
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    q = un / ud;
    r = un % ud;
    if (q >= (longint'(1) << (32 - COORD_FRAC)))
      return neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
    for (int i = 0; i < COORD_FRAC; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= ud) begin
        r = r - ud;
        q = q | 1;
      end
    end
    if (neg) return (q >= 64'h8000_0000) ? 32'sh8000_0000 : 32'(-longint'(q));
    return (q > 64'h7fff_ffff) ? 32'sh7fff_ffff : 32'(q);
  endfunction

  // fold one vertex into the box and queue a result on the last one
  task automatic update_box(tva_pkg::vertex_t v);
    longint x, y, z, w, s;
    logic signed [31:0] t [3];
    tva_pkg::result_t box;
    x = longint'(v.pos_x);
    y = longint'(v.pos_y);
    z = longint'(v.pos_z);
    w = row_dot(mat_row[3], x, y, z);
    if (w == 0) begin
      saw_zero_w = 1'b1;
    end else begin
      for (int a = 0; a < 3; a++) begin
        t[a] = perspective_div(row_dot(mat_row[a], x, y, z), w);
        if (!box_valid || t[a] < box_lo[a]) box_lo[a] = t[a];
        if (!box_valid || t[a] > box_hi[a]) box_hi[a] = t[a];
      end
      box_valid = 1'b1;
    end
    if (v.last_vertex) begin
      box = '0;
      if (box_valid) begin
        s = (longint'(box_lo[0]) + box_hi[0]) >>> 1;
        box.center_x = s[31:0];
        s = (longint'(box_lo[1]) + box_hi[1]) >>> 1;
        box.center_y = s[31:0];
        s = (longint'(box_lo[2]) + box_hi[2]) >>> 1;
        box.center_z = s[31:0];
        s = (longint'(box_hi[0]) - box_lo[0]) >>> 1;
        box.half_x = s[30:0];
        s = (longint'(box_hi[1]) - box_lo[1]) >>> 1;
        box.half_y = s[30:0];
        s = (longint'(box_hi[2]) - box_lo[2]) >>> 1;
        box.half_z = s[30:0];
      end else begin
        box.box_empty = 1'b1;
      end
      box.zero_w_seen = saw_zero_w;
      box_q.insert(box_q.size(), box);
      box_valid = 1'b0;
      saw_zero_w = 1'b0;
    end
  endtask

  // offer one vertex until accepted, then maybe go idle
  task automatic send_vertex(logic signed [31:0] px, logic signed [31:0] py,
                             logic signed [31:0] pz, logic last);
    tva_pkg::vertex_t v;
    v.pos_x = px;
    v.pos_y = py;
    v.pos_z = pz;
    v.last_vertex = last;
    push <= 1'b1;
    vertex <= v;
    @(posedge clk);
    while (full) @(posedge clk);
    update_box(v);
    if ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // stop offering and wait until every expected box has come back
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (box_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [tva_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      tva_pkg::REG_ROW_X: mat_row[0] = data;
      tva_pkg::REG_ROW_Y: mat_row[1] = data;
      tva_pkg::REG_ROW_Z: mat_row[2] = data;
      tva_pkg::REG_ROW_W: mat_row[3] = data;
      default: ;
    endcase
  endtask

  task automatic load_matrix(logic [63:0] rx, logic [63:0] ry, logic [63:0] rz,
                             logic [63:0] rw);
    write_reg(tva_pkg::REG_ROW_X, rx);
    write_reg(tva_pkg::REG_ROW_Y, ry);
    write_reg(tva_pkg::REG_ROW_Z, rz);
    write_reg(tva_pkg::REG_ROW_W, rw);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(65535)) - 32768;
      default: return $signed($urandom_range(32'h00ff_ffff)) - 32'sh0080_0000;
    endcase
  endfunction

  // random matrix: w row mostly well scaled, sometimes wild
  task automatic random_matrix();
    logic [63:0] rw;
    rw = {$urandom, $urandom};
    case ($urandom_range(3))
      0: rw = {16'($urandom_range(16'h0800, 16'h3000)), 48'h0};
      1: rw = {16'($urandom_range(16'h0800, 16'h3000)), 16'h0,
               16'($urandom_range(0, 7)), 16'($urandom_range(0, 7))};
      2: rw = {16'hf000, 48'h0};
      default: ;
    endcase
    load_matrix({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}, rw);
  endtask

  task automatic test_identity();
    load_matrix(tva_pkg::ROW_X_RESET, tva_pkg::ROW_Y_RESET, tva_pkg::ROW_Z_RESET,
                tva_pkg::ROW_W_RESET);
    send_vertex(32'sh7fff_ffff, 32'sh8000_0000, 0, 1'b0);
    send_vertex(32'sh8000_0000, 32'sh7fff_ffff, -1, 1'b1);
    send_vertex(0, 0, 0, 1'b1);
    send_vertex(-1, 1, 32'sh7fff_ffff, 1'b0);
    send_vertex(3, -4, 32'sh8000_0000, 1'b1);
  endtask

  task automatic test_saturation();
    // tiny positive then negative w pushes quotients to both rails
    load_matrix(tva_pkg::ROW_X_RESET, tva_pkg::ROW_Y_RESET, tva_pkg::ROW_Z_RESET,
                64'h0001_0000_0000_0000);
    send_vertex(32'sh0001_0000, -32'sh0001_0000, 5, 1'b0);
    send_vertex(32'sh7fff_ffff, 32'sh8000_0000, 0, 1'b1);
    load_matrix(64'hffff_ffff_ffff_ffff, 64'h7fff_7fff_7fff_7fff,
                64'h8000_8000_8000_8000, 64'hffff_0000_0000_0000);
    send_vertex(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0);
    send_vertex(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1);
  endtask

  task automatic test_zero_w();
    // w = 4096 * x, so x = 0 gives a zero w
    load_matrix(tva_pkg::ROW_X_RESET, tva_pkg::ROW_Y_RESET, tva_pkg::ROW_Z_RESET,
                64'h0000_0000_0000_1000);
    send_vertex(0, 7, 9, 1'b1);
    send_vertex(32'sh0002_0000, 7, 9, 1'b0);
    send_vertex(0, 1, 1, 1'b1);
    send_vertex(0, 1, 1, 1'b0);
    send_vertex(-32'sh0003_0000, -5, 32'sh7fff_ffff, 1'b1);
    load_matrix(64'h0, 64'h0, 64'h0, 64'h0);
    send_vertex(1, 2, 3, 1'b0);
    send_vertex(32'sh7fff_ffff, 0, 0, 1'b1);
  endtask

  task automatic test_register_index();
    load_matrix(tva_pkg::ROW_X_RESET, tva_pkg::ROW_Y_RESET, tva_pkg::ROW_Z_RESET,
                tva_pkg::ROW_W_RESET);
    for (int i = int'(REG_FIRST_UNUSED); i < (1 << tva_pkg::CFG_IDX_W); i++)
      write_reg(i[tva_pkg::CFG_IDX_W-1:0], {$urandom, $urandom});
    send_vertex(100, -200, 300, 1'b0);
    send_vertex(-100, 200, -301, 1'b1);
  endtask

  // random runs under one idling and stalling setting, matrix changed every so often
  task automatic test_random_runs(int idle, int stall, int count);
    int sent;
    int len;
    idle_pct = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < count) begin
      random_matrix();
      repeat (8) begin
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++)
          send_vertex(rand_coord(), rand_coord(), rand_coord(), i == len - 1);
        sent += len;
      end
    end
    drain();
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    load_matrix(tva_pkg::ROW_X_RESET, tva_pkg::ROW_Y_RESET, tva_pkg::ROW_Z_RESET,
                tva_pkg::ROW_W_RESET);
    hold_left = 5000;
    for (int i = 0; i < 40; i++)
      send_vertex(rand_coord(), rand_coord(), rand_coord(), (i % 3) == 2);
    drain();
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    vertex = '0;
    pop = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    cycle_count = 0;
    mat_row[0] = tva_pkg::ROW_X_RESET;
    mat_row[1] = tva_pkg::ROW_Y_RESET;
    mat_row[2] = tva_pkg::ROW_Z_RESET;
    mat_row[3] = tva_pkg::ROW_W_RESET;
    for (int a = 0; a < 3; a++) begin
      box_lo[a] = '0;
      box_hi[a] = '0;
    end
    box_valid = 1'b0;
    saw_zero_w = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_identity();
    test_saturation();
    test_zero_w();
    test_register_index();
    test_backpressure();
    test_random_runs(0, 0, 400);
    test_random_runs(54, 0, 400);
    test_random_runs(0, 54, 400);
    test_random_runs(11, 11, 400);

    drain();
    if (errors == 0) begin
      $display("transformed_vertex_aabb: match");
    end else begin
      $display("transformed_vertex_aabb: mismatch");
    end
    $finish;
  end

endmodule
